// ===== rtl/core/sha1_pkg.sv =====
// sha1_pkg: constants, types and helper functions for the sha-1 stream hasher
// used by the response interface, the controller, the datapath and the top level
`default_nettype none

package sha1_pkg;

   // digest and block geometry
   localparam int DIGEST_WORDS = 5;
   localparam int WORD_IDX_W   = 3;
   localparam int FILL_W       = 6;
   localparam int ROUND_W      = 7;
   localparam int BLOCK_BITS   = 512;
   localparam int COUNT_W      = 64;

   // fill positions inside a 64-byte block
   localparam logic [FILL_W-1:0] LEN_POS  = 6'd56;
   localparam logic [FILL_W-1:0] LAST_POS = 6'd63;

   // round boundaries
   localparam logic [ROUND_W-1:0] ROUND_STAGE1 = 7'd20;
   localparam logic [ROUND_W-1:0] ROUND_STAGE2 = 7'd40;
   localparam logic [ROUND_W-1:0] ROUND_STAGE3 = 7'd60;
   localparam logic [ROUND_W-1:0] LAST_ROUND   = 7'd79;

   // initial chaining values
   localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   // round constants
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   // padding marker byte
   localparam logic [7:0] PAD_MARK = 8'h80;

   // source of the byte shifted into the block buffer
   typedef enum logic [1:0] {
      SRC_MSG,
      SRC_MARK,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   // controller to datapath commands
   typedef struct packed {
      logic                  byte_wr;
      byte_src_type          byte_src;
      logic                  count_inc;
      logic                  round_start;
      logic                  round_step;
      logic                  chain_add;
      logic                  msg_init;
      logic [WORD_IDX_W-1:0] word_sel;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [FILL_W-1:0] fill_pos;
      logic              round_last;
   } dp_status_type;

   // rotate left of a 32-bit word
   function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
      logic [63:0] both;
      both = {x, x} << n;
      return both[63:32];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha1_if.sv =====
// sha1 request and response channel interfaces (valid/ready handshake)
// the response interface depends on sha1_pkg for field widths
`default_nettype none

interface sha1_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, output msg_byte, output has_byte,
                   output end_of_message, input ready);
   modport sink   (input valid, input msg_byte, input has_byte,
                   input end_of_message, output ready);
endinterface

interface sha1_rsp_if import sha1_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [31:0]           digest_word;
   logic [WORD_IDX_W-1:0] word_index;
   logic                  last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sha1_dpath.sv =====
// sha1_dpath: block shift buffer with message schedule, round registers,
// chaining words, fill position and byte count; depends on sha1_pkg
`default_nettype none

module sha1_dpath import sha1_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [7:0]    msg_byte,
   input  wire dp_cmd_type    cmd,
   output      dp_status_type status,
   output      logic [31:0]   digest_word
);

   logic [BLOCK_BITS-1:0] block_ff, block_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [ROUND_W-1:0]    rnd_ff, rnd_in;
   logic [31:0]           a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]           a_in, b_in, c_in, d_in, e_in;
   logic [31:0]           chain_ff [DIGEST_WORDS];
   logic [31:0]           chain_in [DIGEST_WORDS];

   logic [COUNT_W-1:0] bit_len;
   logic [COUNT_W-1:0] len_shift;
   logic [7:0]         byte_val;
   logic [31:0]        w0, w2, w8, w13, sched_new;
   logic [31:0]        f_val, k_val, tmp;

   // byte to shift in
   assign bit_len   = {count_ff[COUNT_W-4:0], 3'b000};
   assign len_shift = bit_len >> {~fill_ff[2:0], 3'b000};

   always_comb begin
      case (cmd.byte_src)
         SRC_MSG:  byte_val = msg_byte;
         SRC_MARK: byte_val = PAD_MARK;
         SRC_ZERO: byte_val = 8'h00;
         SRC_LEN:  byte_val = len_shift[7:0];
         default:  byte_val = 8'h00;
      endcase
   end

   // schedule window taps, w0 is the current round word
   assign w0        = block_ff[BLOCK_BITS-1 -: 32];
   assign w2        = block_ff[BLOCK_BITS-1-2*32 -: 32];
   assign w8        = block_ff[BLOCK_BITS-1-8*32 -: 32];
   assign w13       = block_ff[BLOCK_BITS-1-13*32 -: 32];
   assign sched_new = rol32(w13 ^ w8 ^ w2 ^ w0, 1);

   // block buffer shifts bytes in, then words during the rounds
   always_comb begin
      block_in = block_ff;
      if (cmd.byte_wr) begin
         block_in = {block_ff[BLOCK_BITS-9:0], byte_val};
      end else if (cmd.round_step) begin
         block_in = {block_ff[BLOCK_BITS-33:0], sched_new};
      end
   end

   // round function and constant
   always_comb begin
      if (rnd_ff < ROUND_STAGE1) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K0;
      end else if (rnd_ff < ROUND_STAGE2) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K1;
      end else if (rnd_ff < ROUND_STAGE3) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K3;
      end
   end

   assign tmp = rol32(a_ff, 5) + f_val + e_ff + k_val + w0;

   // working registers
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (cmd.round_start) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end else if (cmd.round_step) begin
         a_in = tmp;
         b_in = a_ff;
         c_in = rol32(b_ff, 30);
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   // chaining words
   always_comb begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
         chain_in[i] = chain_ff[i];
      end
      if (cmd.msg_init) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_in[i] = H_INIT[i];
         end
      end else if (cmd.chain_add) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
   end

   // counters
   always_comb begin
      fill_in  = fill_ff;
      count_in = count_ff;
      rnd_in   = rnd_ff;
      if (cmd.msg_init) begin
         fill_in  = '0;
         count_in = '0;
      end else begin
         if (cmd.byte_wr) begin
            fill_in = fill_ff + 1'b1;
         end
         if (cmd.count_inc) begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.round_start) begin
         rnd_in = '0;
      end else if (cmd.round_step) begin
         rnd_in = rnd_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         count_ff <= '0;
         rnd_ff   <= '0;
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_ff[i] <= H_INIT[i];
         end
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
         rnd_ff   <= rnd_in;
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      block_ff <= block_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
   end

   // status and digest word select
   assign status.fill_pos   = fill_ff;
   assign status.round_last = (rnd_ff == LAST_ROUND);

   always_comb begin
      case (cmd.word_sel)
         3'd0:    digest_word = chain_ff[0];
         3'd1:    digest_word = chain_ff[1];
         3'd2:    digest_word = chain_ff[2];
         3'd3:    digest_word = chain_ff[3];
         3'd4:    digest_word = chain_ff[4];
         default: digest_word = chain_ff[0];
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/sha1_ctrl.sv =====
// sha1_ctrl: sequencer for byte intake, compression rounds, padding and
// digest output; depends on sha1_pkg
`default_nettype none

module sha1_ctrl import sha1_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_has_byte,
   input  wire logic                  req_end,
   output      logic                  req_ready,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [WORD_IDX_W-1:0] rsp_index,
   output      logic                  rsp_last,
   input  wire dp_status_type         status,
   output      dp_cmd_type            cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROUND = 3'd1;
   localparam logic [2:0] S_ADD   = 3'd2;
   localparam logic [2:0] S_PAD   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(DIGEST_WORDS - 1);

   logic [2:0]            state_ff, state_in;
   logic                  end_pend_ff, end_pend_in;
   logic                  mark_done_ff, mark_done_in;
   logic                  final_blk_ff, final_blk_in;
   logic [WORD_IDX_W-1:0] word_ff, word_in;
   logic                  block_full;

   assign block_full = (status.fill_pos == LAST_POS);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      end_pend_in  = end_pend_ff;
      mark_done_in = mark_done_ff;
      final_blk_in = final_blk_ff;
      word_in      = word_ff;
      cmd             = '0;
      cmd.byte_src    = SRC_MSG;
      cmd.word_sel    = word_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.byte_wr   = req_has_byte;
               cmd.count_inc = req_has_byte;
               if (req_has_byte && block_full) begin
                  cmd.round_start = 1'b1;
                  end_pend_in     = req_end;
                  state_in        = S_ROUND;
               end else if (req_end) begin
                  end_pend_in = 1'b1;
                  state_in    = S_PAD;
               end
            end
         end
         S_ROUND: begin
            cmd.round_step = 1'b1;
            if (status.round_last) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.chain_add = 1'b1;
            if (final_blk_ff) begin
               word_in  = '0;
               state_in = S_EMIT;
            end else if (end_pend_ff) begin
               final_blk_in = mark_done_ff;
               state_in     = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            // marker, then zeros, then the bit length in the last block
            cmd.byte_wr = 1'b1;
            if (!mark_done_ff) begin
               cmd.byte_src = SRC_MARK;
               mark_done_in = 1'b1;
               if (status.fill_pos < LEN_POS) begin
                  final_blk_in = 1'b1;
               end
            end else if (final_blk_ff && status.fill_pos >= LEN_POS) begin
               cmd.byte_src = SRC_LEN;
            end else begin
               cmd.byte_src = SRC_ZERO;
            end
            if (block_full) begin
               cmd.round_start = 1'b1;
               state_in        = S_ROUND;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               if (word_ff == LAST_WORD) begin
                  cmd.msg_init = 1'b1;
                  end_pend_in  = 1'b0;
                  mark_done_in = 1'b0;
                  final_blk_in = 1'b0;
                  word_in      = '0;
                  state_in     = S_IDLE;
               end else begin
                  word_in = word_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         end_pend_ff  <= 1'b0;
         mark_done_ff <= 1'b0;
         final_blk_ff <= 1'b0;
         word_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         end_pend_ff  <= end_pend_in;
         mark_done_ff <= mark_done_in;
         final_blk_ff <= final_blk_in;
         word_ff      <= word_in;
      end
   end

   // handshake outputs
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);
   assign rsp_index = word_ff;
   assign rsp_last  = (word_ff == LAST_WORD);

endmodule

`default_nettype wire

// ===== rtl/core/sha1_stream_hasher_top.sv =====
// sha1_stream_hasher_top: at most one message byte per request, sha-1 digest as five
// 32-bit words; instantiates sha1_ctrl and sha1_dpath, uses sha1_pkg, sha1_if
// each full 64-byte block runs 80 rounds and 1 add, during which no request is taken
// end of message: the padding bytes (up to 72) are shifted in and each padded
// block is compressed, then five response words, one per cycle while rsp is ready
// reset (synchronous, active high) restores initial chaining words, count and fill
`default_nettype none

module sha1_stream_hasher_top import sha1_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   sha1_req_if.sink   req_chan,
   sha1_rsp_if.source rsp_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // control
   sha1_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_has_byte (req_chan.has_byte),
      .req_end      (req_chan.end_of_message),
      .req_ready    (req_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_index    (rsp_chan.word_index),
      .rsp_last     (rsp_chan.last_word),
      .status       (status),
      .cmd          (cmd)
   );

   // datapath
   sha1_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .msg_byte    (req_chan.msg_byte),
      .cmd         (cmd),
      .status      (status),
      .digest_word (rsp_chan.digest_word)
   );

endmodule

`default_nettype wire
